@@ rtl/core/lifegen_pkg.sv @@
// lifegen_pkg: sizes, action and register codes, and the controller/datapath
// command and status types for the life automaton generation block
// no dependencies
package lifegen_pkg;

    // grid bounds
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // field widths
    localparam int ACTION_W    = 2;
    localparam int COORD_W     = 6;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // row and column index widths
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);

    // width that holds any register value and either grid bound
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CFG_MAX  = (1 << CFG_DATA_W) - 1;
    localparam int DIM_W    = $clog2(((MAX_DIM > CFG_MAX) ? MAX_DIM : CFG_MAX) + 1);

    // action codes; any other code only reads the cell
    localparam logic [ACTION_W-1:0] ACT_TOGGLE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 7'd64;

    // b3/s23 neighbor counts
    localparam int NB_CNT_W = 4;
    localparam logic [NB_CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NB_CNT_W-1:0] KEEP_COUNT  = 4'd2;

    // row memory read address source
    typedef enum logic [1:0] {
        ADDR_ITEM,
        ADDR_CNT,
        ADDR_CNT_P1,
        ADDR_CNT_P2
    } addr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      rd_en;
        addr_sel_t addr_sel;
        logic      prime;
        logic      step;
        logic      finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic height_zero;
        logic last_row;
    } dp_stat_t;

endpackage

@@ rtl/core/lifegen_if.sv @@
// lifegen_if: valid/ready channels for items, results and register writes
// depends on lifegen_pkg
interface lifegen_item_if;
    import lifegen_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;

    modport source (output valid, output action, output cell_x, output cell_y, input ready);
    modport sink   (input valid, input action, input cell_x, input cell_y, output ready);
endinterface

interface lifegen_result_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic in_range;

    modport source (output valid, output cell_alive, output in_range, input ready);
    modport sink   (input valid, input cell_alive, input in_range, output ready);
endinterface

interface lifegen_cfg_if;
    import lifegen_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lifegen_ram.sv @@
// lifegen_ram: generic single write port, single read port ram, registered read
// no dependencies
module lifegen_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lifegen_ctrl.sv @@
// lifegen_ctrl: sequencer for item handling and the row sweep of a generation
// depends on lifegen_pkg
module lifegen_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic [lifegen_pkg::ACTION_W-1:0] item_action,
    output logic                            item_ready,
    output logic                            result_valid,
    input  logic                            result_ready,
    input  lifegen_pkg::dp_stat_t           stat,
    output lifegen_pkg::dp_cmd_t            cmd
);
    import lifegen_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SW_FIRST,
        SW_SECOND,
        SW_RUN,
        RD_ISSUE,
        RD_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign item_ready   = (state_reg == IDLE);
    assign result_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if ((item_action == ACT_ADVANCE) && !stat.height_zero)
                    begin
                        state_next = SW_FIRST;
                    end
                    else
                    begin
                        state_next = RD_ISSUE;
                    end
                end
            end
            SW_FIRST:
            begin
                // fetch row 0
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_CNT;
                state_next   = SW_SECOND;
            end
            SW_SECOND:
            begin
                // row 0 arrives, fetch row 1
                cmd.prime    = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_CNT_P1;
                state_next   = SW_RUN;
            end
            SW_RUN:
            begin
                // write one new row, fetch two rows ahead
                cmd.step     = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_CNT_P2;
                if (stat.last_row)
                begin
                    state_next = RD_ISSUE;
                end
            end
            RD_ISSUE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_ITEM;
                state_next   = RD_DATA;
            end
            RD_DATA:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/lifegen_dp.sv @@
// lifegen_dp: registers, row memory, row window and b3/s23 row update
// depends on lifegen_pkg and lifegen_ram
module lifegen_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lifegen_pkg::dp_cmd_t               cmd,
    output lifegen_pkg::dp_stat_t              stat,
    input  logic [lifegen_pkg::ACTION_W-1:0]    item_action,
    input  logic [lifegen_pkg::COORD_W-1:0]     item_x,
    input  logic [lifegen_pkg::COORD_W-1:0]     item_y,
    input  logic                               cfg_valid,
    input  logic [lifegen_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lifegen_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                               cell_alive,
    output logic                               in_range
);
    import lifegen_pkg::*;

    logic [CFG_DATA_W-1:0] width_reg,  width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    logic [COORD_W-1:0]    x_reg,      x_next;
    logic [COORD_W-1:0]    y_reg,      y_next;
    logic [ROW_W-1:0]      cnt_reg,    cnt_next;
    logic [MAX_WIDTH-1:0]  prev_reg,   prev_next;
    logic [MAX_WIDTH-1:0]  cur_reg,    cur_next;
    logic [MAX_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                  rd_valid_reg,  rd_valid_next;
    logic                  alive_reg,  alive_next;
    logic                  range_reg,  range_next;

    logic [DIM_W-1:0]     used_w;
    logic [DIM_W-1:0]     used_h;
    logic [DIM_W-1:0]     cnt_p1;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] rd_row;
    logic [MAX_WIDTH-1:0] nxt_row;
    logic [MAX_WIDTH-1:0] prev_m, cur_m, nxt_m;
    logic [MAX_WIDTH-1:0] prev_w, prev_e;
    logic [MAX_WIDTH-1:0] cur_w,  cur_e;
    logic [MAX_WIDTH-1:0] nxt_w,  nxt_e;
    logic [MAX_WIDTH-1:0] life_row;
    logic [COL_W-1:0]     x_idx;
    logic                 addr_ok;
    logic                 cur_bit;
    logic                 flip;

    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [ROW_W-1:0]     ram_raddr;
    logic [MAX_WIDTH-1:0] ram_rdata;

    // b3/s23 rule for one cell
    function automatic logic next_cell(input logic [7:0] nb, input logic self_alive);
        logic [NB_CNT_W-1:0] n;
        n = NB_CNT_W'($countones(nb));
        return (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && self_alive);
    endfunction

    // used area, saturated to the grid bounds
    always_comb
    begin
        used_w = (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : DIM_W'(width_reg);
        used_h = (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : DIM_W'(height_reg);
    end

    assign cnt_p1           = DIM_W'(cnt_reg) + DIM_W'(1);
    assign stat.height_zero = (used_h == '0);
    assign stat.last_row    = (cnt_p1 == used_h);

    // address check of the current item
    assign addr_ok = (DIM_W'(x_reg) < used_w) && (DIM_W'(y_reg) < used_h);
    assign x_idx   = COL_W'(x_reg);
    assign flip    = (action_reg == ACT_TOGGLE);

    // columns in use
    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (DIM_W'(c) < used_w);
        end
    end

    // rows never written read as dead
    assign rd_row  = rd_valid_reg ? ram_rdata : '0;
    assign nxt_row = (cnt_p1 < used_h) ? rd_row : '0;
    assign cur_bit = addr_ok && rd_row[x_idx];

    // three-row window, cells outside the used area count as dead
    assign prev_m = prev_reg & col_mask;
    assign cur_m  = cur_reg  & col_mask;
    assign nxt_m  = nxt_row  & col_mask;

    // bit c of a west row holds column c-1, of an east row column c+1
    assign prev_w = prev_m << 1;
    assign prev_e = prev_m >> 1;
    assign cur_w  = cur_m << 1;
    assign cur_e  = cur_m >> 1;
    assign nxt_w  = nxt_m << 1;
    assign nxt_e  = nxt_m >> 1;

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            life_row[c] = next_cell({prev_w[c], prev_m[c], prev_e[c],
                                     cur_w[c], cur_e[c],
                                     nxt_w[c], nxt_m[c], nxt_e[c]},
                                    cur_reg[c]);
        end
    end

    // read address select
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ITEM:   ram_raddr = ROW_W'(y_reg);
            ADDR_CNT:    ram_raddr = cnt_reg;
            ADDR_CNT_P1: ram_raddr = cnt_reg + ROW_W'(1);
            ADDR_CNT_P2: ram_raddr = cnt_reg + ROW_W'(2);
            default:     ram_raddr = cnt_reg;
        endcase
    end

    // row writes: new generation row or a toggled cell
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = (life_row & col_mask) | (cur_reg & ~col_mask);
        if (cmd.step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && flip && addr_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = ROW_W'(y_reg);
            ram_wdata = rd_row ^ (MAX_WIDTH'(1) << x_idx);
        end
    end

    // next values
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        action_next    = action_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        alive_next     = alive_reg;
        range_next     = range_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  width_next  = cfg_data;
                CFG_IDX_HEIGHT: height_next = cfg_data;
                default:        ;
            endcase
        end

        if (cmd.load)
        begin
            action_next = item_action;
            x_next      = item_x;
            y_next      = item_y;
            cnt_next    = '0;
        end

        if (cmd.rd_en)
        begin
            rd_valid_next = row_valid_reg[ram_raddr];
        end

        if (cmd.prime)
        begin
            prev_next = '0;
            cur_next  = rd_row;
        end

        if (cmd.step)
        begin
            prev_next = cur_reg;
            cur_next  = rd_row;
            cnt_next  = cnt_reg + ROW_W'(1);
        end

        if (ram_we)
        begin
            row_valid_next[ram_waddr] = 1'b1;
        end

        if (cmd.finish)
        begin
            alive_next = cur_bit ^ (flip && addr_ok);
            range_next = addr_ok;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            cnt_reg       <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            cnt_reg       <= cnt_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        alive_reg  <= alive_next;
        range_reg  <= range_next;
    end

    assign cell_alive = alive_reg;
    assign in_range   = range_reg;

    // one row of cells per word
    lifegen_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ rtl/core/life_automaton_generation_top.sv @@
// Life automaton (rule B3/S23) on a grid of up to MAX_WIDTH by MAX_HEIGHT cells
// stored one row per word. Each item gives exactly one result word. A toggle or
// a read passes through a read-issue and a read-data state; an advance first
// sweeps the used rows (skipped when the used height is zero), and the row memory
// delivers one row read and takes one row write per cycle while the sweep slides
// a three-row window down the grid. The next item can be accepted in the cycle
// after the result is registered. One item is worked on at a time; a new item is
// accepted while the last result still waits in the output register, and its own
// result then holds until that register is free. The grid is dead after reset with
// no clearing pass: per-row valid flags make unwritten rows read as dead, so
// items are accepted from the first cycle. Register writes are always accepted
// and must be issued only while the block is idle.
// depends on lifegen_pkg, lifegen_if, lifegen_ctrl, lifegen_dp
module life_automaton_generation_top (
    input  logic             clk,
    input  logic             rst_n,
    lifegen_item_if.sink     item,
    lifegen_result_if.source result,
    lifegen_cfg_if.sink      cfg
);
    import lifegen_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    // sequencer
    lifegen_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_action  (item.action),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // grid storage and cell logic
    lifegen_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item_action (item.action),
        .item_x      (item.cell_x),
        .item_y      (item.cell_y),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cell_alive  (result.cell_alive),
        .in_range    (result.in_range)
    );

endmodule

@@ rtl/core/lifegen_checker.sv @@
// lifegen_checker: port-level assertions for the life automaton top level
// bound to life_automaton_generation_top, no package dependency
module lifegen_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input logic result_cell_alive,
    input logic result_in_range
);

    // a stalled result word stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_cell_alive) && $stable(result_in_range))
        else $error("result payload changed while stalled");

    // an address outside the used grid never reports a live cell
    a_dead_outside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_in_range |-> !result_cell_alive)
        else $error("live cell reported outside the used grid");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in work");

endmodule

bind life_automaton_generation_top lifegen_checker u_lifegen_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_cell_alive (result.cell_alive),
    .result_in_range   (result.in_range)
);
